// File: hw/rtl/image_header_size_sniffer_macros.svh
// Assertion macros for the image header size sniffer.
// Define ASSERT_OFF to compile the checks out.
`ifndef IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold on every clock edge outside reset.
`define IHSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication outside reset.
`define IHSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define IHSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IHSS_ASSERT(label, clk, rst_n, prop, msg)
`define IHSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define IHSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/ihss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image header size sniffer package
// Format and status codes, marker values and signature tables shared by the
// sniffer and its checks.
// ----------------------------------------------------------------------------
package ihss_pkg;

	// Result format codes.
	typedef enum logic [1:0] {
		FMT_UNKNOWN = 2'd0,
		FMT_JPEG    = 2'd1,
		FMT_PNG     = 2'd2
	} format_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_SYNC    = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_SCAN    = 3'd4,
		ST_DIM     = 3'd5,
		ST_TRUNC   = 3'd6,
		ST_NOIHDR  = 3'd7
	} status_t;

	// Marker and signature bytes.
	localparam logic [7:0] BYTE_FF     = 8'hFF;
	localparam logic [7:0] MARK_SOI    = 8'hD8;
	localparam logic [7:0] MARK_TEM    = 8'h01;
	localparam logic [7:0] MARK_RST0   = 8'hD0;
	localparam logic [7:0] MARK_EOI    = 8'hD9;
	localparam logic [7:0] MARK_SOS    = 8'hDA;
	localparam logic [7:0] MARK_SOF_LO = 8'hC0;
	localparam logic [7:0] MARK_SOF_HI = 8'hCF;
	localparam logic [7:0] MARK_DHT    = 8'hC4;
	localparam logic [7:0] MARK_JPG    = 8'hC8;
	localparam logic [7:0] MARK_DAC    = 8'hCC;
	localparam logic [7:0] PNG_LEAD    = 8'h89;

	// Smallest legal segment length and start-of-frame length.
	localparam logic [15:0] MIN_SEG_LEN = 16'd2;
	localparam logic [15:0] MIN_SOF_LEN = 16'd7;

	// Reset value of the largest accepted PNG dimension.
	localparam logic [15:0] MAX_DIM_RESET = 16'd32767;

	// Eight-byte PNG signature, by position.
	function automatic logic [7:0] png_sig(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'h89;
			3'd1: v = 8'h50;
			3'd2: v = 8'h4E;
			3'd3: v = 8'h47;
			3'd4: v = 8'h0D;
			3'd5: v = 8'h0A;
			3'd6: v = 8'h1A;
			default: v = 8'h0A;
		endcase
		return v;
	endfunction

	// IHDR chunk tag, by position.
	function automatic logic [7:0] ihdr_tag(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h49;
			2'd1: v = 8'h48;
			2'd2: v = 8'h44;
			default: v = 8'h52;
		endcase
		return v;
	endfunction

	// Start-of-frame markers: C0..CF except DHT, JPG and DAC.
	function automatic logic is_sof(input logic [7:0] m);
		return (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI) &&
			(m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/image_header_size_sniffer.sv
// Pipeline: a result passes the input register, then the result register, to the output.
// Throughput: one input beat per cycle while results are taken; the input and
// result registers let a new beat enter while a finished result waits to be taken.
// Reset: arst_n clears the parser to the signature phase, empties both registers
// and sets max_png_dimension to 32767. The last beat of a file also clears the parser.
`timescale 1ns / 1ps
`default_nettype none
`include "image_header_size_sniffer_macros.svh"
// ----------------------------------------------------------------------------
// Image header size sniffer
// Reads a file one byte per beat, recognizes JPEG or PNG, and reports the
// image width and height, or the reason it failed, once per file.
// ----------------------------------------------------------------------------
module image_header_size_sniffer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: max_png_dimension.
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  wire logic        s_axis_tlast,  // last_byte
	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata   // format[1:0], status[4:2], width[20:5],
	                                        // height[36:21], zero[39:37]
);

	typedef enum logic [2:0] {
		PH_SIG, PH_JFF, PH_JMARK, PH_JLEN0, PH_JLEN1, PH_JSKIP, PH_JSOF, PH_PNG
	} phase_t;

	// Configuration register.
	logic [15:0] max_dim_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state.
	phase_t              phase_q, phase_d;
	logic [4:0]          idx_q, idx_d;
	logic [15:0]         skip_q, skip_d;
	logic [7:0]          marker_q, marker_d;
	logic [7:0]          len_hi_q, len_hi_d;
	logic [31:0]         wacc_q, wacc_d;
	logic [31:0]         hacc_q, hacc_d;
	logic                decided_q, decided_d;
	ihss_pkg::format_t   fmt_hold_q, fmt_hold_d;

	// Result register.
	logic                out_valid_q;
	ihss_pkg::format_t   out_fmt_q;
	ihss_pkg::status_t   out_st_q;
	logic [15:0]         out_w_q;
	logic [15:0]         out_h_q;

	// Result of the current beat.
	logic                emit;
	logic                dec;
	ihss_pkg::format_t   r_fmt;
	ihss_pkg::status_t   r_st;
	logic [15:0]         r_w;
	logic [15:0]         r_h;
	logic [15:0]         seg_len;
	logic [31:0]         wnext;
	logic [31:0]         hnext;
	logic                advance;
	logic                step;

	// The input register moves whenever the result register can take a beat.
	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_h_q, out_w_q, out_st_q, out_fmt_q};

	// Parser next state and the result of the byte in the input register.
	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		skip_d     = skip_q;
		marker_d   = marker_q;
		len_hi_d   = len_hi_q;
		wacc_d     = wacc_q;
		hacc_d     = hacc_q;
		decided_d  = decided_q;
		fmt_hold_d = fmt_hold_q;
		dec        = 1'b0;
		r_fmt      = ihss_pkg::FMT_UNKNOWN;
		r_st       = ihss_pkg::ST_UNKNOWN;
		r_w        = '0;
		r_h        = '0;
		seg_len    = {len_hi_q, byte_s1};
		wnext      = {wacc_q[23:0], byte_s1};
		hnext      = {hacc_q[23:0], byte_s1};
		if (!decided_q) begin
			unique case (phase_q)
				PH_SIG: begin
					if (idx_q == 5'd0) begin
						if (byte_s1 != ihss_pkg::BYTE_FF && byte_s1 != ihss_pkg::PNG_LEAD) begin
							dec = 1'b1;
						end else begin
							marker_d = byte_s1;
							idx_d    = 5'd1;
						end
					end else if (marker_q == ihss_pkg::BYTE_FF) begin
						if (byte_s1 != ihss_pkg::MARK_SOI) begin
							dec = 1'b1;
						end else begin
							fmt_hold_d = ihss_pkg::FMT_JPEG;
							phase_d    = PH_JFF;
						end
					end else if (byte_s1 != ihss_pkg::png_sig(idx_q[2:0])) begin
						dec = 1'b1;
					end else if (idx_q >= 5'd7) begin
						fmt_hold_d = ihss_pkg::FMT_PNG;
						phase_d    = PH_PNG;
						idx_d      = 5'd8;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				PH_JFF: begin
					if (byte_s1 != ihss_pkg::BYTE_FF) begin
						dec   = 1'b1;
						r_fmt = ihss_pkg::FMT_JPEG;
						r_st  = ihss_pkg::ST_SYNC;
					end else begin
						phase_d = PH_JMARK;
					end
				end
				PH_JMARK: begin
					marker_d = byte_s1;
					if (byte_s1 == ihss_pkg::MARK_TEM ||
						(byte_s1 >= ihss_pkg::MARK_RST0 && byte_s1 <= ihss_pkg::MARK_EOI)) begin
						phase_d = PH_JFF;
					end else begin
						phase_d = PH_JLEN0;
					end
				end
				PH_JLEN0: begin
					len_hi_d = byte_s1;
					phase_d  = PH_JLEN1;
				end
				PH_JLEN1: begin
					r_fmt = ihss_pkg::FMT_JPEG;
					if (seg_len < ihss_pkg::MIN_SEG_LEN) begin
						dec  = 1'b1;
						r_st = ihss_pkg::ST_LENGTH;
					end else if (ihss_pkg::is_sof(marker_q)) begin
						if (seg_len < ihss_pkg::MIN_SOF_LEN) begin
							dec  = 1'b1;
							r_st = ihss_pkg::ST_LENGTH;
						end else begin
							phase_d = PH_JSOF;
							idx_d   = '0;
							wacc_d  = '0;
							hacc_d  = '0;
						end
					end else if (marker_q == ihss_pkg::MARK_SOS) begin
						dec  = 1'b1;
						r_st = ihss_pkg::ST_SCAN;
					end else begin
						skip_d  = seg_len - ihss_pkg::MIN_SEG_LEN;
						phase_d = (seg_len == ihss_pkg::MIN_SEG_LEN) ? PH_JFF : PH_JSKIP;
					end
				end
				PH_JSKIP: begin
					skip_d = skip_q - 16'd1;
					if (skip_q == 16'd1) begin
						phase_d = PH_JFF;
					end
				end
				PH_JSOF: begin
					// Precision byte, then height, then width, each big-endian.
					if (idx_q == 5'd1 || idx_q == 5'd2) begin
						hacc_d = {16'd0, hacc_q[7:0], byte_s1};
					end else if (idx_q >= 5'd3) begin
						wacc_d = {16'd0, wacc_q[7:0], byte_s1};
					end
					if (idx_q >= 5'd4) begin
						dec   = 1'b1;
						r_fmt = ihss_pkg::FMT_JPEG;
						if (wacc_d == '0 || hacc_q == '0) begin
							r_st = ihss_pkg::ST_DIM;
						end else begin
							r_st = ihss_pkg::ST_OK;
							r_w  = wacc_d[15:0];
							r_h  = hacc_q[15:0];
						end
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
				PH_PNG: begin
					if (idx_q >= 5'd12 && idx_q <= 5'd15) begin
						if (byte_s1 != ihss_pkg::ihdr_tag(idx_q[1:0])) begin
							dec   = 1'b1;
							r_fmt = ihss_pkg::FMT_PNG;
							r_st  = ihss_pkg::ST_NOIHDR;
						end
					end else if (idx_q >= 5'd16 && idx_q <= 5'd19) begin
						wacc_d = wnext;
					end else if (idx_q >= 5'd20) begin
						hacc_d = hnext;
					end
					if (!dec) begin
						if (idx_q >= 5'd23) begin
							dec   = 1'b1;
							r_fmt = ihss_pkg::FMT_PNG;
							if (wacc_q == '0 || hacc_d == '0 ||
								wacc_q > {16'd0, max_dim_q} || hacc_d > {16'd0, max_dim_q}) begin
								r_st = ihss_pkg::ST_DIM;
							end else begin
								r_st = ihss_pkg::ST_OK;
								r_w  = wacc_q[15:0];
								r_h  = hacc_d[15:0];
							end
						end else begin
							idx_d = idx_q + 5'd1;
						end
					end
				end
			endcase
			if (dec) begin
				decided_d = 1'b1;
			end else if (last_s1) begin
				// End of file before any decision.
				r_fmt = (phase_d == PH_SIG) ? ihss_pkg::FMT_UNKNOWN : fmt_hold_d;
				r_st  = (phase_d == PH_SIG) ? ihss_pkg::ST_UNKNOWN : ihss_pkg::ST_TRUNC;
			end
		end
		emit = !decided_q && (dec || last_s1);
		// The last beat readies the parser for the next file.
		if (last_s1) begin
			phase_d    = PH_SIG;
			idx_d      = '0;
			skip_d     = '0;
			marker_d   = '0;
			len_hi_d   = '0;
			wacc_d     = '0;
			hacc_d     = '0;
			decided_d  = 1'b0;
			fmt_hold_d = ihss_pkg::FMT_UNKNOWN;
		end
	end

	// Configuration, input register, parser state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q   <= ihss_pkg::MAX_DIM_RESET;
			valid_s1    <= 1'b0;
			byte_s1     <= '0;
			last_s1     <= 1'b0;
			phase_q     <= PH_SIG;
			idx_q       <= '0;
			skip_q      <= '0;
			marker_q    <= '0;
			len_hi_q    <= '0;
			wacc_q      <= '0;
			hacc_q      <= '0;
			decided_q   <= 1'b0;
			fmt_hold_q  <= ihss_pkg::FMT_UNKNOWN;
			out_valid_q <= 1'b0;
			out_fmt_q   <= ihss_pkg::FMT_UNKNOWN;
			out_st_q    <= ihss_pkg::ST_OK;
			out_w_q     <= '0;
			out_h_q     <= '0;
		end else begin
			if (cfg_we) begin
				max_dim_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
				byte_s1  <= s_axis_tdata;
				last_s1  <= s_axis_tlast;
			end
			if (step) begin
				phase_q    <= phase_d;
				idx_q      <= idx_d;
				skip_q     <= skip_d;
				marker_q   <= marker_d;
				len_hi_q   <= len_hi_d;
				wacc_q     <= wacc_d;
				hacc_q     <= hacc_d;
				decided_q  <= decided_d;
				fmt_hold_q <= fmt_hold_d;
			end
			if (advance) begin
				out_valid_q <= step && emit;
				if (step && emit) begin
					out_fmt_q <= r_fmt;
					out_st_q  <= r_st;
					out_w_q   <= r_w;
					out_h_q   <= r_h;
				end
			end
		end
	end

	// Checks on the parser and the result register.
	`IHSS_ASSERT_IMPL(a_ok_has_size, clk, arst_n, out_valid_q && out_st_q == ihss_pkg::ST_OK, out_w_q != 16'd0 && out_h_q != 16'd0, "ok result with zero size")
	`IHSS_ASSERT_IMPL(a_fail_no_size, clk, arst_n, out_valid_q && out_st_q != ihss_pkg::ST_OK, out_w_q == 16'd0 && out_h_q == 16'd0, "failed result carries a size")
	`IHSS_ASSERT_NEXT(a_last_clears, clk, arst_n, step && last_s1, phase_q == PH_SIG && !decided_q && idx_q == 5'd0, "last beat did not clear the parser")
	`IHSS_ASSERT_IMPL(a_decide_emits, clk, arst_n, $rose(decided_q), out_valid_q, "decision without a result")
	`IHSS_ASSERT_IMPL(a_unknown_fmt, clk, arst_n, out_valid_q && out_fmt_q == ihss_pkg::FMT_UNKNOWN, out_st_q == ihss_pkg::ST_UNKNOWN, "unknown format with other status")

endmodule
`default_nettype wire

// File: bench/image_header_size_sniffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image header size sniffer checker
// Follows every input beat with a header parser of its own, queues the size
// report that each file must produce, and compares every report leaving the
// sniffer with the oldest one queued, field by field.
// ----------------------------------------------------------------------------
module image_header_size_sniffer_checker
	import ihss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
	input  logic        s_axis_tlast,   // last_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // format[1:0], status[4:2], width[20:5],
	                                    // height[36:21], zero[39:37]
	output int          mismatches,
	output int          reports_due
);

	localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
	localparam logic [31:0] IHDR_TAG  = 32'h49484452;

	// Where the parser stands within the current file.
	typedef enum logic [2:0] {
		STEP_SIG,
		STEP_SEEK_FF,
		STEP_MARKER,
		STEP_LEN_HI,
		STEP_LEN_LO,
		STEP_SKIP,
		STEP_FRAME,
		STEP_PNG
	} parse_step_t;

	typedef struct packed {
		format_t     fmt;
		status_t     st;
		logic [15:0] w;
		logic [15:0] h;
	} size_report_t;

	size_report_t size_reports[$];
	size_report_t want;
	size_report_t got;

	logic [15:0] dim_limit = MAX_DIM_RESET;
	parse_step_t step = STEP_SIG;
	logic [4:0]  index = '0;
	logic [15:0] skip_left = '0;
	logic [7:0]  marker = '0;
	logic [15:0] seg_len = '0;
	logic [31:0] w_acc = '0;
	logic [31:0] h_acc = '0;
	logic        settled = 1'b0;
	format_t     fmt = FMT_UNKNOWN;
	int          errors = 0;

	// Queue the one report of the current file and ignore the rest of it.
	task automatic settle(input format_t f, input status_t s, input logic [31:0] w,
		input logic [31:0] h);
		size_report_t r;
		r.fmt = f;
		r.st = s;
		r.w = (s == ST_OK) ? w[15:0] : 16'd0;
		r.h = (s == ST_OK) ? h[15:0] : 16'd0;
		size_reports.push_back(r);
		settled = 1'b1;
	endtask

	task automatic clear_file();
		step = STEP_SIG;
		index = '0;
		skip_left = '0;
		marker = '0;
		seg_len = '0;
		w_acc = '0;
		h_acc = '0;
		settled = 1'b0;
		fmt = FMT_UNKNOWN;
	endtask

	// Advance the parser by one byte of the file.
	task automatic sniff_byte(input logic [7:0] b, input logic last);
		logic frame;
		frame = 1'b0;
		if (!settled) begin
			case (step)
				STEP_SIG: begin
					if (index == 0) begin
						if (b != BYTE_FF && b != PNG_LEAD) begin
							settle(FMT_UNKNOWN, ST_UNKNOWN, 0, 0);
						end else begin
							marker = b;
							index = 1;
						end
					end else if (marker == BYTE_FF) begin
						if (b != MARK_SOI) begin
							settle(FMT_UNKNOWN, ST_UNKNOWN, 0, 0);
						end else begin
							fmt = FMT_JPEG;
							step = STEP_SEEK_FF;
						end
					end else if (b != PNG_MAGIC[63 - 8 * index[2:0] -: 8]) begin
						settle(FMT_UNKNOWN, ST_UNKNOWN, 0, 0);
					end else if (index >= 7) begin
						fmt = FMT_PNG;
						step = STEP_PNG;
						index = 8;
					end else begin
						index = index + 1;
					end
				end
				STEP_SEEK_FF: begin
					if (b != BYTE_FF)
						settle(FMT_JPEG, ST_SYNC, 0, 0);
					else
						step = STEP_MARKER;
				end
				STEP_MARKER: begin
					marker = b;
					if (b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_EOI))
						step = STEP_SEEK_FF;
					else
						step = STEP_LEN_HI;
				end
				STEP_LEN_HI: begin
					seg_len = {b, 8'h00};
					step = STEP_LEN_LO;
				end
				STEP_LEN_LO: begin
					seg_len = seg_len | {8'h00, b};
					frame = (marker >= MARK_SOF_LO) && (marker <= MARK_SOF_HI) &&
						(marker != MARK_DHT) && (marker != MARK_JPG) && (marker != MARK_DAC);
					if (seg_len < MIN_SEG_LEN) begin
						settle(FMT_JPEG, ST_LENGTH, 0, 0);
					end else if (frame) begin
						if (seg_len < MIN_SOF_LEN) begin
							settle(FMT_JPEG, ST_LENGTH, 0, 0);
						end else begin
							step = STEP_FRAME;
							index = '0;
							w_acc = '0;
							h_acc = '0;
						end
					end else if (marker == MARK_SOS) begin
						settle(FMT_JPEG, ST_SCAN, 0, 0);
					end else begin
						skip_left = seg_len - MIN_SEG_LEN;
						step = (skip_left == 0) ? STEP_SEEK_FF : STEP_SKIP;
					end
				end
				STEP_SKIP: begin
					skip_left = skip_left - 1;
					if (skip_left == 0)
						step = STEP_SEEK_FF;
				end
				STEP_FRAME: begin
					// Precision byte first, then height and width, big-endian.
					if (index == 1 || index == 2)
						h_acc = {16'h0000, h_acc[7:0], b};
					else if (index >= 3)
						w_acc = {16'h0000, w_acc[7:0], b};
					if (index >= 4) begin
						if (w_acc == 0 || h_acc == 0)
							settle(FMT_JPEG, ST_DIM, 0, 0);
						else
							settle(FMT_JPEG, ST_OK, w_acc, h_acc);
					end else begin
						index = index + 1;
					end
				end
				default: begin
					// PNG: chunk length skipped, then the IHDR tag, width and height.
					if (index >= 12 && index <= 15) begin
						if (b != IHDR_TAG[31 - 8 * (index - 12) -: 8])
							settle(FMT_PNG, ST_NOIHDR, 0, 0);
					end else if (index >= 16 && index <= 19) begin
						w_acc = {w_acc[23:0], b};
					end else if (index >= 20) begin
						h_acc = {h_acc[23:0], b};
					end
					if (!settled) begin
						if (index >= 23) begin
							if (w_acc == 0 || h_acc == 0 || w_acc > dim_limit ||
								h_acc > dim_limit)
								settle(FMT_PNG, ST_DIM, 0, 0);
							else
								settle(FMT_PNG, ST_OK, w_acc, h_acc);
						end else begin
							index = index + 1;
						end
					end
				end
			endcase
			// A file that ends undecided reports how far it got.
			if (!settled && last) begin
				if (step == STEP_SIG)
					settle(FMT_UNKNOWN, ST_UNKNOWN, 0, 0);
				else
					settle(fmt, ST_TRUNC, 0, 0);
			end
		end
		if (last)
			clear_file();
	endtask

	// Track the register, predict on input beats and compare on output beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_limit = MAX_DIM_RESET;
			clear_file();
			size_reports.delete();
		end else begin
			if (cfg_we)
				dim_limit = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				sniff_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.fmt = format_t'(m_axis_tdata[1:0]);
				got.st = status_t'(m_axis_tdata[4:2]);
				got.w = m_axis_tdata[20:5];
				got.h = m_axis_tdata[36:21];
				if (size_reports.size() == 0) begin
					$display("%0t: size report with none expected, tdata %h", $time,
						m_axis_tdata);
					errors++;
				end else begin
					want = size_reports.pop_front();
					if (got.fmt !== want.fmt) begin
						$display("%0t: format expected %0d, actual %0d", $time, want.fmt,
							got.fmt);
						errors++;
					end
					if (got.st !== want.st) begin
						$display("%0t: status expected %0d, actual %0d", $time, want.st,
							got.st);
						errors++;
					end
					if (got.w !== want.w) begin
						$display("%0t: width expected %0d, actual %0d", $time, want.w, got.w);
						errors++;
					end
					if (got.h !== want.h) begin
						$display("%0t: height expected %0d, actual %0d", $time, want.h,
							got.h);
						errors++;
					end
				end
			end
		end
		mismatches <= errors;
		reports_due <= size_reports.size();
	end

endmodule

// File: bench/image_header_size_sniffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image header size sniffer testbench
// Feeds short JPEG, PNG, broken and noise files to the sniffer under random
// gaps and back-pressure, over several settings of the PNG size limit, and
// gives the verdict from the checker's mismatch count and pending reports.
// ----------------------------------------------------------------------------
module image_header_size_sniffer_tb;
	import ihss_pkg::*;

	localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
	localparam logic [31:0] IHDR_TAG  = 32'h49484452;
	localparam int          BEATS_PER_PHASE = 270;
	localparam int          WATCHDOG_LIMIT = 1000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // data_byte[7:0]
	logic        s_axis_tlast;   // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // format[1:0], status[4:2], width[20:5],
	                             // height[36:21], zero[39:37]
	int          mismatches;
	int          reports_due;

	logic [7:0]  file_bytes[$];
	int          dim_limit = MAX_DIM_RESET;
	int          beats_sent = 0;
	int          idle_cycles = 0;
	logic        no_gaps = 1'b0;

	image_header_size_sniffer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	image_header_size_sniffer_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.reports_due   (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Result side: stall for a random number of cycles before each beat.
	initial begin
		int hold;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = no_gaps ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		beats_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_beat(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	// Hold the input until every queued report has come out and the pipe is empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (reports_due != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put16(input logic [15:0] v);
		file_bytes.push_back(v[15:8]);
		file_bytes.push_back(v[7:0]);
	endtask

	task automatic put32(input logic [31:0] v);
		put16(v[31:16]);
		put16(v[15:0]);
	endtask

	task automatic put_random(input int n);
		repeat (n) file_bytes.push_back($urandom_range(0, 255));
	endtask

	// A marker that is neither standalone, nor a frame start, nor a scan start.
	function automatic logic [7:0] plain_marker();
		logic [7:0] m;
		do m = $urandom_range(0, 255);
		while ((m >= MARK_SOF_LO && m <= MARK_SOF_HI && m != MARK_DHT && m != MARK_JPG &&
			m != MARK_DAC) || m == MARK_SOS || m == MARK_TEM ||
			(m >= MARK_RST0 && m <= MARK_EOI));
		return m;
	endfunction

	function automatic logic [7:0] frame_marker();
		logic [7:0] m;
		do m = $urandom_range(MARK_SOF_LO, MARK_SOF_HI);
		while (m == MARK_DHT || m == MARK_JPG || m == MARK_DAC);
		return m;
	endfunction

	// PNG dimension: mostly legal, sometimes zero, at the limit or beyond it.
	function automatic logic [31:0] png_dim();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return dim_limit;
			2: return dim_limit + 1;
			3: return $urandom;
			default: return (dim_limit == 0) ? $urandom_range(1, 255) :
				$urandom_range(1, dim_limit);
		endcase
	endfunction

	// Build one random file: mostly well-formed headers, plus broken ones and noise.
	task automatic build_file();
		int kind;
		int n;
		int cut;
		logic [7:0] wrong;
		logic [31:0] tag;
		file_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			file_bytes.push_back(BYTE_FF);
			file_bytes.push_back(MARK_SOI);
			repeat ($urandom_range(0, 3)) begin
				file_bytes.push_back(BYTE_FF);
				if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(0, 10);
					file_bytes.push_back((n == 10) ? MARK_TEM : MARK_RST0 + n);
				end else begin
					file_bytes.push_back(plain_marker());
					n = $urandom_range(2, 8);
					put16(n);
					put_random(n - 2);
				end
			end
			if (kind >= 35) begin
				// Broken JPEG streams.
				case ($urandom_range(0, 4))
					0: begin
						file_bytes.push_back($urandom_range(0, 254));
						put_random($urandom_range(0, 3));
					end
					1: begin
						file_bytes.push_back(BYTE_FF);
						file_bytes.push_back($urandom_range(0, 1) ? frame_marker() :
							plain_marker());
						put16($urandom_range(0, 1));
					end
					2: begin
						file_bytes.push_back(BYTE_FF);
						file_bytes.push_back(frame_marker());
						put16($urandom_range(2, 6));
					end
					3: begin
						file_bytes.push_back(BYTE_FF);
						file_bytes.push_back(MARK_SOS);
						put16($urandom_range(2, 65535));
						put_random($urandom_range(0, 3));
					end
					default: begin
						file_bytes.push_back(BYTE_FF);
						file_bytes.push_back(plain_marker());
						put16($urandom_range(256, 65535));
						put_random($urandom_range(1, 8));
					end
				endcase
			end else begin
				file_bytes.push_back(BYTE_FF);
				file_bytes.push_back(frame_marker());
				put16(($urandom_range(0, 3) == 0) ? $urandom_range(7, 65535) :
					$urandom_range(7, 17));
				put_random(1);
				put16(($urandom_range(0, 7) == 0) ? 16'd0 : $urandom_range(0, 65535));
				put16(($urandom_range(0, 7) == 0) ? 16'd0 : $urandom_range(0, 65535));
				put_random($urandom_range(0, 4));
			end
		end else if (kind < 75) begin
			put32(PNG_MAGIC[63:32]);
			put32(PNG_MAGIC[31:0]);
			put32($urandom);
			tag = IHDR_TAG;
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(0, 3);
				tag[8 * n +: 8] = tag[8 * n +: 8] ^ 8'($urandom_range(1, 255));
			end
			put32(tag);
			put32(png_dim());
			put32(png_dim());
			put_random($urandom_range(0, 4));
		end else if (kind < 87) begin
			// Signature that breaks partway through.
			if ($urandom_range(0, 1)) begin
				file_bytes.push_back(BYTE_FF);
				do wrong = $urandom_range(0, 255); while (wrong == MARK_SOI);
			end else begin
				n = $urandom_range(1, 7);
				for (int i = 0; i < n; i++)
					file_bytes.push_back(PNG_MAGIC[63 - 8 * i -: 8]);
				do wrong = $urandom_range(0, 255); while (wrong == PNG_MAGIC[63 - 8 * n -: 8]);
			end
			file_bytes.push_back(wrong);
			put_random($urandom_range(0, 3));
		end else begin
			put_random($urandom_range(1, 10));
			if ($urandom_range(0, 2) == 0)
				file_bytes[0] = $urandom_range(0, 1) ? BYTE_FF : PNG_LEAD;
		end
		// Cut some files short at a random point.
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut)
				file_bytes.delete(file_bytes.size() - 1);
		end
	endtask

	initial begin
		int target;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed files: one-byte files, a bare start marker, a sync loss,
		// a scan before the frame and the largest JPEG size.
		file_bytes = '{8'h00};
		send_file();
		file_bytes = '{BYTE_FF};
		send_file();
		file_bytes = '{PNG_LEAD};
		send_file();
		file_bytes = '{BYTE_FF, MARK_SOI};
		send_file();
		file_bytes = '{BYTE_FF, MARK_SOI, 8'h00};
		send_file();
		file_bytes = '{BYTE_FF, MARK_SOI, BYTE_FF, MARK_EOI, BYTE_FF, MARK_SOS, 8'h00, 8'h02};
		send_file();
		file_bytes = '{BYTE_FF, MARK_SOI, BYTE_FF, MARK_SOF_LO, 8'h00, 8'h07, 8'h08,
			8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_file();

		// Random files over several limits, the reset value first.
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				drain();
				case (phase)
					1: dim_limit = 0;
					2: dim_limit = 1;
					3: dim_limit = 65535;
					4: dim_limit = $urandom_range(2, 65534);
					default: dim_limit = 300;
				endcase
				cfg_we <= 1'b1;
				cfg_wdata <= dim_limit;
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			target = beats_sent + BEATS_PER_PHASE;
			while (beats_sent < target) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				build_file();
				send_file();
				if ($urandom_range(0, 15) == 0)
					drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && reports_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
